@@ design/fcd_pkg.sv @@
// ----------------------------------------------------------------------------
// fcd_pkg: shared types and constants for the framed CRC16 packet deframer
// Item kinds passed from the byte classifier to the status/CRC stage, frame
// status codes, and the byte-wide CRC16-XMODEM update.
// ----------------------------------------------------------------------------
package fcd_pkg;

    localparam logic [7:0]  START_BYTE = 8'h02;
    localparam logic [7:0]  END_BYTE   = 8'h03;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    // Frame status codes
    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_CRC      = 3'd2;
    localparam logic [2:0] ST_BAD_END  = 3'd3;
    localparam logic [2:0] ST_ZERO_LEN = 3'd4;
    localparam logic [2:0] ST_TRUNC    = 3'd5;

    // Classifier to back-end queue
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        K_NONE,
        K_ZERO_LEN,
        K_BODY,
        K_CRC_HI,
        K_CRC_LO,
        K_END
    } fcd_kind_t;

    typedef struct packed {
        fcd_kind_t  kind;
        logic [7:0] data;
        logic       first;   // first body byte: packet id, restart CRC
        logic       trunc;   // chunk ended inside the frame
        logic [7:0] plen;    // body length minus one, used on the end byte
    } fcd_item_t;

    // One byte of CRC16-XMODEM, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ design/fcd_front.sv @@
// ----------------------------------------------------------------------------
// fcd_front: byte classifier
// Tracks the frame phase and body count for each accepted byte and pushes a
// classified record into the queue toward the status/CRC stage.
// ----------------------------------------------------------------------------
module fcd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               s_chunk_last,
    input  logic               q_ready,
    output logic               q_push,
    output fcd_pkg::fcd_item_t q_item
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY,
        PH_CRC_HI,
        PH_CRC_LO,
        PH_END
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] blen_reg, blen_next;

    assign s_ready = q_ready;
    assign q_push  = s_valid && q_ready;

    // Classify the byte and advance the frame phase
    always_comb begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        blen_next    = blen_reg;
        q_item.kind  = fcd_pkg::K_NONE;
        q_item.data  = s_rx_byte;
        q_item.first = 1'b0;
        q_item.plen  = blen_reg - 8'd1;
        case (phase_reg)
            PH_LEN: begin
                if (s_rx_byte == 8'd0) begin
                    q_item.kind = fcd_pkg::K_ZERO_LEN;
                    phase_next  = PH_HUNT;
                end else begin
                    blen_next  = s_rx_byte;
                    left_next  = s_rx_byte;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY: begin
                q_item.kind  = fcd_pkg::K_BODY;
                q_item.first = (left_reg == blen_reg);
                left_next    = left_reg - 8'd1;
                if (left_reg == 8'd1) begin
                    phase_next = PH_CRC_HI;
                end
            end
            PH_CRC_HI: begin
                q_item.kind = fcd_pkg::K_CRC_HI;
                phase_next  = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                q_item.kind = fcd_pkg::K_CRC_LO;
                phase_next  = PH_END;
            end
            PH_END: begin
                q_item.kind = fcd_pkg::K_END;
                phase_next  = PH_HUNT;
            end
            default: begin
                phase_next = (s_rx_byte == fcd_pkg::START_BYTE) ? PH_LEN : PH_HUNT;
            end
        endcase
        // Drop an unfinished frame at chunk end
        q_item.trunc = s_chunk_last && (phase_next != PH_HUNT);
        if (q_item.trunc) begin
            phase_next = PH_HUNT;
        end
    end

    // Hold frame state, advance on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            left_reg  <= 8'd0;
            blen_reg  <= 8'd0;
        end else if (q_push) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            blen_reg  <= blen_next;
        end
    end

endmodule

@@ design/fcd_fifo.sv @@
// ----------------------------------------------------------------------------
// fcd_fifo: short queue of classified bytes
// Decouples the classifier from the status/CRC stage so each side can stall
// on its own.
// ----------------------------------------------------------------------------
module fcd_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  fcd_pkg::fcd_item_t push_item,
    output logic               push_ready,
    input  logic               pop,
    output logic               pop_valid,
    output fcd_pkg::fcd_item_t pop_item
);

    fcd_pkg::fcd_item_t mem [fcd_pkg::FIFO_DEPTH];

    logic [fcd_pkg::PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [fcd_pkg::CNT_W-1:0] count_reg;

    assign push_ready = (count_reg != fcd_pkg::CNT_W'(fcd_pkg::FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];

    // Store pushed records
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == fcd_pkg::PTR_W'(fcd_pkg::FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + fcd_pkg::PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == fcd_pkg::PTR_W'(fcd_pkg::FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + fcd_pkg::PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + fcd_pkg::CNT_W'(1);
                2'b01:   count_reg <= count_reg - fcd_pkg::CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ design/fcd_back.sv @@
// ----------------------------------------------------------------------------
// fcd_back: CRC check and result register
// Pops classified bytes, keeps the running CRC over the body, decides the
// frame status on the end byte, a zero length or a truncation, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module fcd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  fcd_pkg::fcd_item_t q_item,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_body_valid,
    output logic [7:0]         m_body_byte,
    output logic               m_is_packet_id,
    output logic [2:0]         m_frame_status,
    output logic [7:0]         m_payload_length
);

    logic        m_valid_reg;
    logic        bvalid_reg, bvalid_next;
    logic [7:0]  bbyte_reg, bbyte_next;
    logic        pid_reg, pid_next;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  plen_reg, plen_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;

    assign q_pop = q_valid && (!m_valid_reg || m_ready);

    // Work out the result for the popped byte
    always_comb begin
        crc_next    = crc_reg;
        crc_hi_next = crc_hi_reg;
        bvalid_next = 1'b0;
        bbyte_next  = 8'd0;
        pid_next    = 1'b0;
        status_next = fcd_pkg::ST_NONE;
        plen_next   = 8'd0;
        case (q_item.kind)
            fcd_pkg::K_ZERO_LEN: begin
                status_next = fcd_pkg::ST_ZERO_LEN;
            end
            fcd_pkg::K_BODY: begin
                bvalid_next = 1'b1;
                bbyte_next  = q_item.data;
                pid_next    = q_item.first;
                crc_next    = fcd_pkg::crc16_byte(q_item.first ? 16'd0 : crc_reg,
                                                  q_item.data);
            end
            fcd_pkg::K_CRC_HI: begin
                crc_hi_next = q_item.data;
            end
            fcd_pkg::K_CRC_LO: begin
                crc_next = crc_reg ^ {crc_hi_reg, q_item.data};
            end
            fcd_pkg::K_END: begin
                if (q_item.data != fcd_pkg::END_BYTE) begin
                    status_next = fcd_pkg::ST_BAD_END;
                end else if (crc_reg != 16'd0) begin
                    status_next = fcd_pkg::ST_CRC;
                end else begin
                    status_next = fcd_pkg::ST_OK;
                    plen_next   = q_item.plen;
                end
            end
            default: begin
                status_next = fcd_pkg::ST_NONE;
            end
        endcase
        if (q_item.trunc) begin
            status_next = fcd_pkg::ST_TRUNC;
        end
    end

    // Hold CRC state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            crc_reg     <= 16'd0;
            crc_hi_reg  <= 8'd0;
        end else begin
            if (q_pop) begin
                m_valid_reg <= 1'b1;
                crc_reg     <= crc_next;
                crc_hi_reg  <= crc_hi_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            bvalid_reg <= bvalid_next;
            bbyte_reg  <= bbyte_next;
            pid_reg    <= pid_next;
            status_reg <= status_next;
            plen_reg   <= plen_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_body_valid     = bvalid_reg;
    assign m_body_byte      = bbyte_reg;
    assign m_is_packet_id   = pid_reg;
    assign m_frame_status   = status_reg;
    assign m_payload_length = plen_reg;

    // A body byte carries no final status other than truncation
    a_body_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_body_valid |->
            (m_frame_status == fcd_pkg::ST_NONE || m_frame_status == fcd_pkg::ST_TRUNC))
        else $error("body byte reported with a final frame status");

    // Payload length is only reported with an accepted frame
    a_plen_ok_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_status != fcd_pkg::ST_OK |-> m_payload_length == 8'd0)
        else $error("payload length set without accepted frame");

    // Packet id only marks a body byte
    a_pid_body: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_packet_id |-> m_body_valid)
        else $error("packet id flag without body byte");

    // No pop while a result is stalled
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !q_pop)
        else $error("result register overwritten while stalled");

endmodule

@@ design/framed_crc16_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// framed_crc16_packet_deframer: STX/length/body/CRC16/ETX frame parser
// Top level: classifier, queue and CRC/status stage.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while the output is not stalled and
// returns exactly one result per byte. Frames are 0x02, a nonzero length L,
// L body bytes (packet id first), a big-endian CRC16-XMODEM over the body and
// 0x03. Body bytes are passed on as they arrive; the end byte reports
// accepted, CRC error or bad end, with the payload length on an accepted
// frame. Sustained rate is one byte per cycle while the output is not
// stalled: the CRC advances a whole byte per cycle in the status stage. A
// byte's result passes one queue slot and the result register before it is
// offered; while a result waits, the two-entry queue takes two more bytes
// before the input stalls.
// ----------------------------------------------------------------------------
module framed_crc16_packet_deframer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_chunk_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_body_valid,
    output logic [7:0] m_body_byte,
    output logic       m_is_packet_id,
    output logic [2:0] m_frame_status,
    output logic [7:0] m_payload_length
);

    logic               push, push_ready, pop, pop_valid;
    fcd_pkg::fcd_item_t push_item, pop_item;

    // Classify incoming bytes
    fcd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .s_chunk_last (s_chunk_last),
        .q_ready      (push_ready),
        .q_push       (push),
        .q_item       (push_item)
    );

    // Buffer classified bytes
    fcd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item)
    );

    // Check CRC and produce results
    fcd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (pop_valid),
        .q_item           (pop_item),
        .q_pop            (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_body_valid     (m_body_valid),
        .m_body_byte      (m_body_byte),
        .m_is_packet_id   (m_is_packet_id),
        .m_frame_status   (m_frame_status),
        .m_payload_length (m_payload_length)
    );

endmodule

@@ test/fcd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_checker: result predictor and scoreboard for the CRC16 packet deframer
// Watches both channels of the block. Every input transfer runs through a
// byte-level frame parser kept here, and the expected result is queued; every
// output transfer is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module fcd_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_chunk_last,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_body_valid,
    input  logic [7:0] m_body_byte,
    input  logic       m_is_packet_id,
    input  logic [2:0] m_frame_status,
    input  logic [7:0] m_payload_length,
    output int         fail_count,
    output int         pending
);

    localparam int PRINT_CAP = 50;

    typedef enum logic [2:0] {
        P_HUNT,
        P_LEN,
        P_BODY,
        P_CRC_HI,
        P_CRC_LO,
        P_END
    } parse_phase_t;

    typedef struct packed {
        logic       body_valid;
        logic [7:0] body_byte;
        logic       is_pid;
        logic [2:0] status;
        logic [7:0] plen;
    } frame_result_t;

    // Parser state
    parse_phase_t  rx_phase;
    logic [7:0]    body_left;
    logic [7:0]    body_len;
    logic [15:0]   body_crc;
    logic [7:0]    crc_hi_rx;

    frame_result_t expected_q[$];
    frame_result_t exp_r;
    int            mismatch_cnt = 0;
    int            result_cnt = 0;

    // Shift one byte into the CRC16-XMODEM register, one bit at a time
    function automatic logic [15:0] crc_xmodem_next(input logic [15:0] crc,
                                                    input logic [7:0]  b);
        logic [15:0] c;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            c = {c[14:0], 1'b0} ^ ((c[15] ^ b[k]) ? fcd_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // Advance the frame parser by one byte and form its result
    task automatic parse_byte(input logic [7:0] b, input logic last,
                              output frame_result_t r);
        r = '0;
        r.status = fcd_pkg::ST_NONE;
        case (rx_phase)
            P_LEN: begin
                if (b == 8'h00) begin
                    r.status = fcd_pkg::ST_ZERO_LEN;
                    rx_phase = P_HUNT;
                end else begin
                    body_len  = b;
                    body_left = b;
                    body_crc  = '0;
                    rx_phase  = P_BODY;
                end
            end
            P_BODY: begin
                r.body_valid = 1'b1;
                r.body_byte  = b;
                r.is_pid     = (body_left == body_len);
                body_crc     = crc_xmodem_next(body_crc, b);
                body_left    = body_left - 8'd1;
                if (body_left == 8'd0) begin
                    rx_phase = P_CRC_HI;
                end
            end
            P_CRC_HI: begin
                crc_hi_rx = b;
                rx_phase  = P_CRC_LO;
            end
            P_CRC_LO: begin
                // zero afterwards means the received CRC matched
                body_crc = body_crc ^ {crc_hi_rx, b};
                rx_phase = P_END;
            end
            P_END: begin
                if (b != fcd_pkg::END_BYTE) begin
                    r.status = fcd_pkg::ST_BAD_END;
                end else if (body_crc != 16'h0000) begin
                    r.status = fcd_pkg::ST_CRC;
                end else begin
                    r.status = fcd_pkg::ST_OK;
                    r.plen   = body_len - 8'd1;
                end
                rx_phase = P_HUNT;
            end
            default: begin
                rx_phase = (b == fcd_pkg::START_BYTE) ? P_LEN : P_HUNT;
            end
        endcase
        // drop an unfinished frame at the end of a chunk
        if (last && rx_phase != P_HUNT) begin
            r.status = fcd_pkg::ST_TRUNC;
            rx_phase = P_HUNT;
        end
    endtask

    task automatic flag(input string msg);
        if (mismatch_cnt < PRINT_CAP) begin
            $display("[%0t] result %0d: %s", $realtime, result_cnt, msg);
        end
        mismatch_cnt++;
    endtask

    // Predict on input transfers, compare on output transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_phase  = P_HUNT;
            body_left = '0;
            body_len  = '0;
            body_crc  = '0;
            crc_hi_rx = '0;
            expected_q.delete();
            pending    <= 0;
            fail_count <= mismatch_cnt;
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_rx_byte, s_chunk_last, exp_r);
                expected_q.push_back(exp_r);
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    flag("result transfer with nothing expected");
                end else begin
                    exp_r = expected_q.pop_front();
                    if (m_body_valid !== exp_r.body_valid) begin
                        flag($sformatf("body_valid expected %0d got %0d",
                                       exp_r.body_valid, m_body_valid));
                    end
                    if (m_body_byte !== exp_r.body_byte) begin
                        flag($sformatf("body_byte expected %02h got %02h",
                                       exp_r.body_byte, m_body_byte));
                    end
                    if (m_is_packet_id !== exp_r.is_pid) begin
                        flag($sformatf("is_packet_id expected %0d got %0d",
                                       exp_r.is_pid, m_is_packet_id));
                    end
                    if (m_frame_status !== exp_r.status) begin
                        flag($sformatf("frame_status expected %0d got %0d",
                                       exp_r.status, m_frame_status));
                    end
                    if (m_payload_length !== exp_r.plen) begin
                        flag($sformatf("payload_length expected %0d got %0d",
                                       exp_r.plen, m_payload_length));
                    end
                end
                result_cnt++;
            end
            pending    <= expected_q.size();
            fail_count <= mismatch_cnt;
        end
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the framed CRC16 packet deframer
// Builds a byte stream of directed corner frames followed by random good,
// corrupted, truncated and zero-length frames mixed with noise, sends it in
// bursts with gaps while the result side stalls on its own pattern, and
// reports the checker's outcome once every expected result has arrived.
// ----------------------------------------------------------------------------
module tb_top;

    typedef enum int {
        FL_NONE,
        FL_CRC,
        FL_END,
        FL_TRUNC
    } frame_flaw_t;

    localparam int STREAM_TARGET = 950;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 150;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       s_chunk_last;
    logic       m_valid;
    logic       m_ready;
    logic       m_body_valid;
    logic [7:0] m_body_byte;
    logic       m_is_packet_id;
    logic [2:0] m_frame_status;
    logic [7:0] m_payload_length;
    int         fail_count;
    int         pending;

    logic [7:0] tx_bytes[$];
    logic       tx_lasts[$];
    int         next_idx;
    int         sent_cnt;
    int         gap_left;
    int         burst_left;
    int         cycle_cnt;
    int         pick;
    int         len;
    int         noise_n;
    bit         end_last;
    int         rx_mode;
    int         rx_mode_left;
    bit         hold_done;
    int         phase_cnt;

    framed_crc16_packet_deframer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .s_chunk_last     (s_chunk_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_body_valid     (m_body_valid),
        .m_body_byte      (m_body_byte),
        .m_is_packet_id   (m_is_packet_id),
        .m_frame_status   (m_frame_status),
        .m_payload_length (m_payload_length)
    );

    fcd_checker chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .s_chunk_last     (s_chunk_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_body_valid     (m_body_valid),
        .m_body_byte      (m_body_byte),
        .m_is_packet_id   (m_is_packet_id),
        .m_frame_status   (m_frame_status),
        .m_payload_length (m_payload_length),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    task automatic put_byte(input logic [7:0] b, input logic last);
        tx_bytes.push_back(b);
        tx_lasts.push_back(last);
    endtask

    // Append one frame; fill < 0 gives random body bytes
    task automatic add_frame(input int flen, input frame_flaw_t flaw,
                             input bit last_on_end, input int fill);
        logic [7:0]  frame[$];
        logic [7:0]  b;
        logic [15:0] crc;
        int          cut;
        crc = '0;
        frame.push_back(fcd_pkg::START_BYTE);
        frame.push_back(8'(flen));
        for (int i = 0; i < flen; i++) begin
            b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
            frame.push_back(b);
            for (int k = 7; k >= 0; k--) begin
                crc = {crc[14:0], 1'b0} ^
                      ((crc[15] ^ b[k]) ? fcd_pkg::CRC_POLY : 16'h0000);
            end
        end
        if (flaw == FL_CRC) begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        frame.push_back(crc[15:8]);
        frame.push_back(crc[7:0]);
        b = fcd_pkg::END_BYTE;
        if (flaw == FL_END) begin
            // any value but the end marker
            b = 8'($urandom_range(0, 254));
            if (b >= fcd_pkg::END_BYTE) begin
                b = b + 8'd1;
            end
        end
        frame.push_back(b);
        cut = (flaw == FL_TRUNC) ? int'($urandom_range(0, frame.size() - 2))
                                 : frame.size() - 1;
        for (int i = 0; i <= cut; i++) begin
            put_byte(frame[i], (i == cut) && (flaw == FL_TRUNC || last_on_end));
        end
    endtask

    // Abort on a hung run
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
        $display("TEST FAILED");
        $finish;
    end

    // Result side: stall on changing patterns, with one long hold-off
    initial begin
        m_ready      = 1'b0;
        rx_mode      = 0;
        rx_mode_left = 0;
        hold_done    = 1'b0;
        phase_cnt    = 0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (!hold_done && sent_cnt >= HOLD_AT) begin
                // hold off long enough to back up the input
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(5, 80);
                end
                rx_mode_left--;
                phase_cnt++;
                case (rx_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 7) == 0);
                    default: m_ready <= (phase_cnt % 3 != 0);
                endcase
            end
        end
    end

    // Build the stream, send it, then wait out the results
    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_rx_byte    = 8'h00;
        s_chunk_last = 1'b0;
        sent_cnt     = 0;

        // Directed: idle bytes at the extremes, chunk end while hunting
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b1);
        // zero length on a chunk end still reports zero length
        put_byte(fcd_pkg::START_BYTE, 1'b0);
        put_byte(8'h00, 1'b1);
        // shortest good frame finishing on a chunk end
        add_frame(1, FL_NONE, 1'b1, 8'hFF);
        // chunk end right on the start byte
        put_byte(fcd_pkg::START_BYTE, 1'b1);
        // wrong end marker, then CRC error with a body byte equal to the start
        add_frame(1, FL_END, 1'b0, 8'h00);
        add_frame(1, FL_CRC, 1'b0, fcd_pkg::START_BYTE);

        // Random: half well-formed frames, the rest broken frames and noise
        add_frame(255, FL_NONE, 1'b0, -1);
        while (tx_bytes.size() < STREAM_TARGET) begin
            pick     = $urandom_range(0, 99);
            len      = ($urandom_range(0, 49) == 0) ? $urandom_range(17, 255)
                                                    : $urandom_range(1, 16);
            end_last = ($urandom_range(0, 5) == 0);
            if (pick < 50) begin
                add_frame(len, FL_NONE, end_last, -1);
            end else if (pick < 60) begin
                add_frame(len, FL_CRC, end_last, -1);
            end else if (pick < 68) begin
                add_frame(len, FL_END, end_last, -1);
            end else if (pick < 73) begin
                put_byte(fcd_pkg::START_BYTE, 1'b0);
                put_byte(8'h00, end_last);
            end else if (pick < 83) begin
                add_frame(len, FL_TRUNC, 1'b0, -1);
            end else begin
                noise_n = $urandom_range(1, 4);
                for (int k = 0; k < noise_n; k++) begin
                    put_byte(8'($urandom_range(0, 255)),
                             (k == noise_n - 1) && ($urandom_range(0, 1) == 1));
                end
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Offer bytes in bursts; advance only after a transfer
        next_idx   = 0;
        gap_left   = 0;
        burst_left = $urandom_range(1, 40);
        while (sent_cnt < tx_bytes.size()) begin
            @(posedge aclk);
            if (s_valid && s_ready) begin
                sent_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (next_idx < tx_bytes.size()) begin
                    s_valid      <= 1'b1;
                    s_rx_byte    <= tx_bytes[next_idx];
                    s_chunk_last <= tx_lasts[next_idx];
                    next_idx++;
                    burst_left--;
                    if (burst_left == 0) begin
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 40);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end

        // Drain outstanding results, then allow for stray ones
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
